FILE: rtl/sfp_pkg.sv
`default_nettype none
package sfp_pkg;

  localparam int RUN_CNT_W = 4;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef enum logic [1:0] {
    REG_CRC_ENABLE    = 2'd0,
    REG_HEADER_LENGTH = 2'd1,
    REG_HEADER_WORD   = 2'd2,
    REG_LENGTH_WIDTH  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [RUN_CNT_W-1:0] hdr_cnt;
    logic [RUN_CNT_W-1:0] len_cnt;
    logic [16:0]          field;
    logic                 has_pay;
    logic [7:0]           pay_byte;
    logic                 has_crc;
    logic [15:0]          crc;
    logic                 frame_done;
  } run_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b & BYTE_MASK};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sfp_builder.sv
`default_nettype none
module sfp_builder import sfp_pkg::*; #(
  parameter int MAX_HEADER_BYTES = 4,
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  payload_byte,
  input  wire logic [15:0] frame_length,
  input  wire logic        crc_enable,
  input  wire logic [2:0]  header_length,
  input  wire logic [2:0]  length_width,
  output run_t             run,
  output logic             run_nonempty
);

  logic        in_frame;
  logic [15:0] bytes_left;
  logic [15:0] crc_accum;

  logic        in_frame_next;
  logic [15:0] bytes_left_next;
  logic [15:0] crc_accum_next;

  logic [RUN_CNT_W-1:0] hl;
  logic [RUN_CNT_W-1:0] lw;
  logic [15:0]          bl_base;
  logic [15:0]          bl;
  logic [15:0]          crc_upd;
  logic                 has_pay;

  always_comb begin
    hl = (32'(header_length) > MAX_HEADER_BYTES) ? RUN_CNT_W'(MAX_HEADER_BYTES)
                                                 : RUN_CNT_W'(header_length);
    lw = (32'(length_width) > MAX_LENGTH_BYTES) ? RUN_CNT_W'(MAX_LENGTH_BYTES)
                                                : RUN_CNT_W'(length_width);
    bl_base = in_frame ? bytes_left : frame_length;
    has_pay = in_frame || (frame_length != 16'd0);
    bl      = bl_base - 16'd1;
    crc_upd = crc16_update(in_frame ? crc_accum : CRC_INIT, payload_byte);

    run.hdr_cnt    = in_frame ? '0 : hl;
    run.len_cnt    = in_frame ? '0 : lw;
    run.field      = {1'b0, frame_length} + (crc_enable ? 17'd2 : 17'd0);
    run.has_pay    = has_pay;
    run.pay_byte   = payload_byte;
    run.has_crc    = crc_enable && (!has_pay || bl == 16'd0);
    run.crc        = has_pay ? crc_upd : CRC_INIT;
    run.frame_done = !has_pay || bl == 16'd0;
    run_nonempty   = (run.hdr_cnt != '0) || (run.len_cnt != '0) || run.has_pay || run.has_crc;

    in_frame_next   = has_pay && bl != 16'd0;
    bytes_left_next = has_pay ? bl : 16'd0;
    crc_accum_next  = has_pay ? crc_upd : CRC_INIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      bytes_left <= 16'd0;
      crc_accum  <= CRC_INIT;
    end else if (accept) begin
      in_frame   <= in_frame_next;
      bytes_left <= bytes_left_next;
      crc_accum  <= crc_accum_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sfp_emitter.sv
`default_nettype none
module sfp_emitter import sfp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire run_t        load_run,
  input  wire logic [31:0] header_word,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             run_end,
  output logic             frame_end
);

  typedef enum logic [2:0] {
    P_HDR, P_LEN, P_PAY, P_CRC_LO, P_CRC_HI, P_NONE
  } phase_t;

  logic                 busy;
  phase_t               phase;
  logic [RUN_CNT_W-1:0] idx;
  run_t                 run;

  phase_t               phase_next;
  logic [RUN_CNT_W-1:0] idx_next;
  logic [RUN_CNT_W-1:0] sh;

  function automatic phase_t first_at(input run_t r, input phase_t from);
    phase_t p;
    p = P_NONE;
    if ((from == P_HDR || from == P_LEN || from == P_PAY || from == P_CRC_LO) && r.has_crc)
      p = P_CRC_LO;
    if ((from == P_HDR || from == P_LEN || from == P_PAY) && r.has_pay)
      p = P_PAY;
    if ((from == P_HDR || from == P_LEN) && r.len_cnt != '0)
      p = P_LEN;
    if (from == P_HDR && r.hdr_cnt != '0)
      p = P_HDR;
    return p;
  endfunction

  always_comb begin
    idx_next   = '0;
    phase_next = P_NONE;
    case (phase)
      P_HDR: begin
        if (idx + 1'b1 < run.hdr_cnt) begin
          phase_next = P_HDR;
          idx_next   = idx + 1'b1;
        end else begin
          phase_next = first_at(run, P_LEN);
        end
      end
      P_LEN: begin
        if (idx + 1'b1 < run.len_cnt) begin
          phase_next = P_LEN;
          idx_next   = idx + 1'b1;
        end else begin
          phase_next = first_at(run, P_PAY);
        end
      end
      P_PAY:    phase_next = first_at(run, P_CRC_LO);
      P_CRC_LO: phase_next = P_CRC_HI;
      default:  phase_next = P_NONE;
    endcase
  end

  always_comb begin
    sh = run.len_cnt - 1'b1 - idx;
    case (phase)
      P_HDR:    out_byte = 8'(64'(header_word) >> (32'(idx) << 3));
      P_LEN:    out_byte = 8'({15'd0, run.field} >> (32'(sh) << 3));
      P_PAY:    out_byte = run.pay_byte;
      P_CRC_LO: out_byte = run.crc[7:0];
      P_CRC_HI: out_byte = run.crc[15:8];
      default:  out_byte = 8'h00;
    endcase
    out_valid = busy;
    run_end   = phase_next == P_NONE;
    frame_end = run_end && run.frame_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= P_NONE;
      idx   <= '0;
    end else if (load) begin
      busy  <= 1'b1;
      phase <= first_at(load_run, P_HDR);
      idx   <= '0;
      run   <= load_run;
    end else if (busy && out_ready) begin
      busy  <= phase_next != P_NONE;
      phase <= phase_next;
      idx   <= idx_next;
    end
  end

  a_busy_phase: assert property (@(posedge clk) disable iff (rst)
    busy |-> phase != P_NONE)
    else $error("busy with no byte to send");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (load && busy) |-> (out_ready && run_end))
    else $error("new item loaded over an unfinished one");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && out_ready && !run_end && !load) |=> busy)
    else $error("item dropped before its last byte");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (busy && frame_end) |-> run_end)
    else $error("frame end not on last byte of item");

endmodule
`default_nettype wire

FILE: rtl/serial_frame_packer_core.sv
// Serial frame packer.
// Input channel (in_valid/in_ready): one payload byte per item; the first
// item of a frame also carries frame_length. A zero-length frame is a single
// item whose payload_byte is ignored.
// Output channel (out_valid/out_ready): one framed byte per item, with
// run_end on the last byte caused by an input item and frame_end on the
// last byte of a frame (header, big-endian length, payload, CRC-16 low first).
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// write only while the packer is idle.
// The first output byte is presented in the cycle after the input item is taken.
// Throughput: the next item is taken in the cycle the last byte of the current
// one leaves, so payload streams at one byte per cycle while out_ready stays
// high. An item causing no byte produces no output.
// When out_ready is low the current byte holds and in_ready drops.
// Reset: config returns to defaults, the packer waits for a frame start
// and the CRC restarts at 0xFFFF.
`default_nettype none
module serial_frame_packer_core import sfp_pkg::*; #(
  parameter int MAX_HEADER_BYTES = 4,
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  payload_byte,
  input  wire logic [15:0] frame_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             run_end,
  output logic             frame_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic        crc_enable;
  logic [2:0]  header_length;
  logic [31:0] header_word;
  logic [2:0]  length_width;

  run_t run;
  logic run_nonempty;
  logic accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || (out_ready && run_end);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_enable    <= 1'b0;
      header_length <= 3'd2;
      header_word   <= 32'd42330;
      length_width  <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_CRC_ENABLE:    crc_enable    <= cfg_data[0];
        REG_HEADER_LENGTH: header_length <= cfg_data[2:0];
        REG_HEADER_WORD:   header_word   <= cfg_data;
        REG_LENGTH_WIDTH:  length_width  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  sfp_builder #(
    .MAX_HEADER_BYTES(MAX_HEADER_BYTES),
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_builder (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .crc_enable   (crc_enable),
    .header_length(header_length),
    .length_width (length_width),
    .run          (run),
    .run_nonempty (run_nonempty)
  );

  sfp_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && run_nonempty),
    .load_run   (run),
    .header_word(header_word),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .frame_end  (frame_end)
  );

endmodule
`default_nettype wire

FILE: dv/tb_serial_frame_packer_core.sv
`timescale 1ns / 100ps
module tb_serial_frame_packer_core;
  import sfp_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       last_of_item;
    logic       last_of_frame;
  } framed_byte_t;

  // one row of the directed plan: either a full register set or an item,
  // optionally with its bytes typed in (first byte sent is the leftmost)
  typedef struct packed {
    logic        is_cfg;
    logic        crc_on;
    logic [2:0]  hdr_len;
    logic [31:0] hdr_word;
    logic [2:0]  len_width;
    logic [7:0]  pb;
    logic [15:0] fl;
    logic        typed;
    logic [3:0]  n_exp;
    logic [87:0] exp_bytes;
    logic        exp_fe;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  payload_byte;
  logic [15:0] frame_length;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        run_end;
  logic        frame_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // packer model: configuration and frame state
  logic        crc_en_m;
  logic [2:0]  hdr_len_m;
  logic [31:0] hdr_word_m;
  logic [2:0]  len_width_m;
  logic        in_frame_m;
  logic [15:0] left_m;
  logic [15:0] crc_m;

  framed_byte_t packed_now[$];
  framed_byte_t due_bytes[$];
  framed_byte_t want;
  plan_row_t    plan[$];

  int gap_pct;
  int stall_pct;
  int n_items;
  int n_bytes;
  int n_frames;
  int n_cfg;
  int n_errors;
  int cycles;

  serial_frame_packer_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .run_end      (run_end),
    .frame_end    (frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [15:0] crc16_modbus(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ d[k];
      r = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic void add_byte(input logic [7:0] d, input logic fe);
    packed_now.push_back('{data: d, last_of_item: 1'b0, last_of_frame: fe});
  endfunction

  // bytes one accepted item produces, into packed_now
  function automatic void pack_item(input logic [7:0] pb, input logic [15:0] fl);
    int          hl;
    int          lw;
    int          sh;
    logic [31:0] fld;
    packed_now.delete();
    if (!in_frame_m) begin
      hl = (hdr_len_m > 3'd4) ? 4 : int'(hdr_len_m);
      lw = (len_width_m > 3'd4) ? 4 : int'(len_width_m);
      fld = {16'h0, fl} + (crc_en_m ? 32'd2 : 32'd0);
      crc_m = CRC_INIT;
      for (int i = 0; i < hl; i++)
        add_byte(hdr_word_m[8*i +: 8], (i + 1 == hl) && lw == 0 && fl == 0 && !crc_en_m);
      for (int i = 0; i < lw; i++) begin
        sh = 8 * (lw - 1 - i);
        add_byte(fld[sh +: 8], (i + 1 == lw) && fl == 0 && !crc_en_m);
      end
      if (fl == 0) begin
        if (crc_en_m) begin
          add_byte(crc_m[7:0], 1'b0);
          add_byte(crc_m[15:8], 1'b1);
        end
        in_frame_m = 1'b0;
        left_m = 16'h0;
      end else begin
        crc_m = crc16_modbus(crc_m, pb);
        left_m = fl - 16'd1;
        in_frame_m = 1'b1;
      end
    end else begin
      crc_m = crc16_modbus(crc_m, pb);
      left_m = left_m - 16'd1;
    end
    if (in_frame_m) begin
      add_byte(pb, left_m == 0 && !crc_en_m);
      if (left_m == 0) begin
        if (crc_en_m) begin
          add_byte(crc_m[7:0], 1'b0);
          add_byte(crc_m[15:8], 1'b1);
        end
        in_frame_m = 1'b0;
      end
    end
    if (packed_now.size() > 0) packed_now[packed_now.size() - 1].last_of_item = 1'b1;
  endfunction

  function automatic plan_row_t cfg_row(input logic crc, input logic [2:0] hl,
                                        input logic [31:0] hw, input logic [2:0] lw);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.crc_on = crc;
    r.hdr_len = hl;
    r.hdr_word = hw;
    r.len_width = lw;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic [7:0] pb, input logic [15:0] fl,
                                          input logic [3:0] n, input logic [87:0] b,
                                          input logic fe);
    plan_row_t r;
    r = '0;
    r.pb = pb;
    r.fl = fl;
    r.typed = 1'b1;
    r.n_exp = n;
    r.exp_bytes = b;
    r.exp_fe = fe;
    return r;
  endfunction

  function automatic plan_row_t item_row(input logic [7:0] pb, input logic [15:0] fl);
    plan_row_t r;
    r = typed_row(pb, fl, 4'd0, 88'h0, 1'b0);
    r.typed = 1'b0;
    return r;
  endfunction

  task automatic send_item(input logic [7:0] pb, input logic [15:0] fl, input logic typed,
                           input logic [3:0] n, input logic [87:0] b, input logic fe);
    while (int'($urandom_range(99)) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    payload_byte <= pb;
    frame_length <= fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
    pack_item(pb, fl);
    if (typed) begin
      for (int k = 0; k < n; k++)
        due_bytes.push_back('{data: b[8*(n-1-k) +: 8], last_of_item: k == n - 1,
                              last_of_frame: fe && k == n - 1});
    end else begin
      foreach (packed_now[k]) due_bytes.push_back(packed_now[k]);
    end
  endtask

  task automatic hold_until_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CRC_ENABLE:    crc_en_m = d[0];
      REG_HEADER_LENGTH: hdr_len_m = d[2:0];
      REG_HEADER_WORD:   hdr_word_m = d;
      REG_LENGTH_WIDTH:  len_width_m = d[2:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic crc, input logic [2:0] hl, input logic [31:0] hw,
                           input logic [2:0] lw);
    hold_until_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_CRC_ENABLE, {31'h0, crc});
    write_reg(REG_HEADER_LENGTH, {29'h0, hl});
    write_reg(REG_HEADER_WORD, hw);
    write_reg(REG_LENGTH_WIDTH, {29'h0, lw});
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  // receiver: random back-pressure and byte checking
  always @(posedge clk) begin
    out_ready <= (int'($urandom_range(99)) >= stall_pct);
    if (!rst && out_valid && out_ready) begin
      n_bytes++;
      if (frame_end) n_frames++;
      if (due_bytes.size() == 0) begin
        $display("%0t: byte 0x%02h with nothing expected", $time, out_byte);
        n_errors++;
      end else begin
        want = due_bytes.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte exp 0x%02h got 0x%02h", $time, want.data, out_byte);
          n_errors++;
        end
        if (run_end !== want.last_of_item) begin
          $display("%0t: run_end exp %0b got %0b", $time, want.last_of_item, run_end);
          n_errors++;
        end
        if (frame_end !== want.last_of_frame) begin
          $display("%0t: frame_end exp %0b got %0b", $time, want.last_of_frame, frame_end);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out, %0d bytes outstanding", $time, due_bytes.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int seg_items;
    int len;
    rst <= 1'b1;
    in_valid <= 1'b0;
    payload_byte <= 8'h0;
    frame_length <= 16'h0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_CRC_ENABLE;
    cfg_data <= 32'h0;
    n_items = 0;
    n_bytes = 0;
    n_frames = 0;
    n_cfg = 0;
    n_errors = 0;
    cycles = 0;
    gap_pct = 24;
    stall_pct = 59;
    crc_en_m = 1'b0;
    hdr_len_m = 3'd2;
    hdr_word_m = 32'd42330;
    len_width_m = 3'd1;
    in_frame_m = 1'b0;
    left_m = 16'h0;
    crc_m = CRC_INIT;

    // defaults after reset: no CRC, header 5A A5, one length byte
    plan.push_back(typed_row(8'h11, 16'h0000, 4'd3, 88'h5AA500, 1'b1));
    plan.push_back(typed_row(8'hFF, 16'h0001, 4'd4, 88'h5AA501FF, 1'b1));
    plan.push_back(typed_row(8'h00, 16'h0003, 4'd4, 88'h5AA50300, 1'b0));
    plan.push_back(typed_row(8'h80, 16'hFFFF, 4'd1, 88'h80, 1'b0));
    plan.push_back(typed_row(8'h7F, 16'h0000, 4'd1, 88'h7F, 1'b1));
    // CRC on: empty payload gives FF FF
    plan.push_back(cfg_row(1'b1, 3'd2, 32'h0000A55A, 3'd1));
    plan.push_back(typed_row(8'hC3, 16'h0000, 4'd5, 88'h5AA502FFFF, 1'b1));
    plan.push_back(item_row(8'hAA, 16'h0002));
    plan.push_back(item_row(8'h55, 16'h1234));
    // nothing configured: empty frame produces no bytes
    plan.push_back(cfg_row(1'b0, 3'd0, 32'h0, 3'd0));
    plan.push_back(typed_row(8'h01, 16'h0000, 4'd0, 88'h0, 1'b0));
    plan.push_back(typed_row(8'h3C, 16'h0001, 4'd1, 88'h3C, 1'b1));
    // oversized widths saturate at four bytes
    plan.push_back(cfg_row(1'b1, 3'd7, 32'hFFFFFFFF, 3'd7));
    plan.push_back(typed_row(8'h00, 16'h0000, 4'd10, 88'hFFFFFFFF00000002FFFF, 1'b1));
    plan.push_back(item_row(8'h96, 16'h0001));
    plan.push_back(cfg_row(1'b0, 3'd4, 32'h01020304, 3'd0));
    plan.push_back(typed_row(8'hE7, 16'h0001, 4'd5, 88'h04030201E7, 1'b1));
    plan.push_back(cfg_row(1'b0, 3'd1, 32'h000000AB, 3'd3));
    plan.push_back(typed_row(8'h11, 16'h0002, 4'd5, 88'hAB00000211, 1'b0));
    plan.push_back(typed_row(8'h22, 16'h0000, 4'd1, 88'h22, 1'b1));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].is_cfg)
        apply_cfg(plan[k].crc_on, plan[k].hdr_len, plan[k].hdr_word, plan[k].len_width);
      else
        send_item(plan[k].pb, plan[k].fl, plan[k].typed, plan[k].n_exp,
                  plan[k].exp_bytes, plan[k].exp_fe);
    end

    for (int seg = 0; seg < 9; seg++) begin
      if (seg < 3) begin
        gap_pct = 24;
        stall_pct = 59;
      end else if (seg < 6) begin
        gap_pct = 59;
        stall_pct = 24;
      end else begin
        gap_pct = 0;
        stall_pct = 0;
      end
      apply_cfg(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom,
                3'($urandom_range(0, 7)));
      seg_items = 0;
      while (seg_items < 15) begin
        case ($urandom_range(0, 9))
          0:       len = 0;
          1:       len = $urandom_range(7, 40);
          default: len = $urandom_range(1, 6);
        endcase
        if ($urandom_range(0, 19) == 0) hold_until_empty();
        for (int k = 0; k < ((len == 0) ? 1 : len); k++) begin
          send_item(8'($urandom_range(0, 255)),
                    (k == 0) ? len[15:0] : 16'($urandom_range(0, 65535)),
                    1'b0, 4'd0, 88'h0, 1'b0);
          seg_items++;
        end
      end
    end

    // long frame: length field truncation
    apply_cfg(1'b0, 3'd1, $urandom, 3'd1);
    for (int k = 0; k < 256; k++)
      send_item(8'($urandom_range(0, 255)),
                (k == 0) ? 16'd256 : 16'($urandom_range(0, 65535)),
                1'b0, 4'd0, 88'h0, 1'b0);

    hold_until_empty();
    repeat (8) @(posedge clk);
    $display("covered %0d items, %0d frames, %0d framed bytes; %0d mismatches",
             n_items, n_frames, n_bytes, n_errors);
    $display("%0d register settings incl. zero and oversized widths, CRC on and off",
             n_cfg);
    if (n_errors == 0 && due_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
